FILE: sv/i2crts_pkg.sv
package i2crts_pkg;

  // Sizing
  localparam int BUFFER_DEPTH_DEF = 16;
  localparam int COUNT_W          = 5;

  typedef logic [COUNT_W-1:0] count_t;

  // Command codes
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_TX_RDY  = 3'd3;
  localparam logic [2:0] CMD_RX_BYTE = 3'd4;

  // Phase codes as seen on the result
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_REG    = 3'd1;
  localparam logic [2:0] PH_SWITCH = 3'd2;
  localparam logic [2:0] PH_RX     = 3'd3;
  localparam logic [2:0] PH_TX     = 3'd4;

  // Sequencer state, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REG    = 5'b00010,
    ST_SWITCH = 5'b00100,
    ST_RX     = 5'b01000,
    ST_TX     = 5'b10000
  } seq_state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] dev_id;
    logic [7:0] reg_id;
    logic [4:0] count;
    logic [7:0] data;
    logic [3:0] index;
  } in_item_t;

  typedef struct packed {
    logic       start_request;
    logic       receive_dir;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       stop_request;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_data;
    logic [6:0] target_addr;
    logic [2:0] phase;
    logic       done_res;
  } out_item_t;

  // One-hot state to external phase code
  function automatic logic [2:0] phase_code(seq_state_t st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:   code = PH_IDLE;
      ST_REG:    code = PH_REG;
      ST_SWITCH: code = PH_SWITCH;
      ST_RX:     code = PH_RX;
      ST_TX:     code = PH_TX;
      default:   code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/i2crts_ram.sv
module i2crts_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/i2crts_step.sv
module i2crts_step #(
  parameter int BUFFER_DEPTH = i2crts_pkg::BUFFER_DEPTH_DEF,
  parameter int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  i2crts_pkg::in_item_t  item,
  input  logic [7:0]            store_rdata,
  output i2crts_pkg::out_item_t result,
  output logic                  store_we,
  output logic [ADDR_W-1:0]     store_waddr,
  output logic [7:0]            store_wdata,
  output logic [ADDR_W-1:0]     store_raddr
);

  i2crts_pkg::seq_state_t phase_r, phase_nxt;
  logic [7:0]             reg_id_r, reg_id_nxt;
  logic [6:0]             dev_id_r, dev_id_nxt;
  i2crts_pkg::count_t     rx_rem_r, rx_rem_nxt;
  i2crts_pkg::count_t     tx_rem_r, tx_rem_nxt;
  i2crts_pkg::count_t     rx_pos_r, rx_pos_nxt;
  i2crts_pkg::count_t     tx_pos_r, tx_pos_nxt;

  i2crts_pkg::count_t     cnt_clamped;
  i2crts_pkg::count_t     rx_rem_left;
  logic                   load_in_range;
  logic                   start, txv, stop, rxv, done;
  logic [7:0]             txb, rxd;
  logic [3:0]             rxi;

  // Count clamp and load slot range
  assign cnt_clamped   = (9'(item.count) > 9'(BUFFER_DEPTH)) ?
                         i2crts_pkg::COUNT_W'(BUFFER_DEPTH) : item.count;
  assign load_in_range = 9'(item.index) < 9'(BUFFER_DEPTH);

  // Next state and result for the item in the input register
  always_comb begin
    phase_nxt    = phase_r;
    reg_id_nxt   = reg_id_r;
    dev_id_nxt   = dev_id_r;
    rx_rem_nxt   = rx_rem_r;
    tx_rem_nxt   = tx_rem_r;
    rx_pos_nxt   = rx_pos_r;
    tx_pos_nxt   = tx_pos_r;
    rx_rem_left  = rx_rem_r;
    start        = 1'b0;
    txv          = 1'b0;
    txb          = 8'd0;
    stop         = 1'b0;
    rxv          = 1'b0;
    rxi          = 4'd0;
    rxd          = 8'd0;
    done         = 1'b0;
    store_we     = 1'b0;

    unique case (item.cmd)
      i2crts_pkg::CMD_LOAD: begin
        store_we = adv & load_in_range;
      end
      i2crts_pkg::CMD_READ, i2crts_pkg::CMD_WRITE: begin
        phase_nxt    = i2crts_pkg::ST_REG;
        reg_id_nxt   = item.reg_id;
        dev_id_nxt   = item.dev_id;
        rx_rem_nxt   = (item.cmd == i2crts_pkg::CMD_READ) ? cnt_clamped : '0;
        tx_rem_nxt   = (item.cmd == i2crts_pkg::CMD_READ) ? '0 : cnt_clamped;
        rx_pos_nxt   = '0;
        tx_pos_nxt   = '0;
        start        = 1'b1;
      end
      i2crts_pkg::CMD_TX_RDY: begin
        unique case (phase_r)
          i2crts_pkg::ST_REG: begin
            txv       = 1'b1;
            txb       = reg_id_r;
            phase_nxt = (rx_rem_r != '0) ? i2crts_pkg::ST_SWITCH : i2crts_pkg::ST_TX;
          end
          i2crts_pkg::ST_SWITCH: begin
            start     = 1'b1;
            phase_nxt = i2crts_pkg::ST_RX;
            stop      = (rx_rem_r == i2crts_pkg::COUNT_W'(1));
          end
          i2crts_pkg::ST_TX: begin
            if (tx_rem_r != '0) begin
              txv        = 1'b1;
              txb        = store_rdata;
              tx_pos_nxt = tx_pos_r + 1'b1;
              tx_rem_nxt = tx_rem_r - 1'b1;
            end else begin
              stop      = 1'b1;
              phase_nxt = i2crts_pkg::ST_IDLE;
              done      = 1'b1;
            end
          end
          default: ;
        endcase
      end
      i2crts_pkg::CMD_RX_BYTE: begin
        if (phase_r == i2crts_pkg::ST_RX) begin
          if (rx_rem_r != '0) begin
            rxv         = 1'b1;
            rxi         = rx_pos_r[3:0];
            rxd         = item.data;
            rx_pos_nxt  = rx_pos_r + 1'b1;
            rx_rem_left = rx_rem_r - 1'b1;
          end
          rx_rem_nxt = rx_rem_left;
          if (rx_rem_left == i2crts_pkg::COUNT_W'(1)) begin
            stop = 1'b1;
          end else if (rx_rem_left == '0) begin
            phase_nxt = i2crts_pkg::ST_IDLE;
            done      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Store port: write on load, read prefetches the next tx slot
  assign store_waddr = ADDR_W'(item.index);
  assign store_wdata = item.data;
  assign store_raddr = adv ? ADDR_W'(tx_pos_nxt) : ADDR_W'(tx_pos_r);

  // Result fields
  always_comb begin
    result.start_request = start;
    result.receive_dir   = (phase_nxt == i2crts_pkg::ST_RX);
    result.tx_valid      = txv;
    result.tx_byte       = txb;
    result.stop_request  = stop;
    result.rx_valid      = rxv;
    result.rx_index      = rxi;
    result.rx_data       = rxd;
    result.target_addr   = dev_id_nxt;
    result.phase         = i2crts_pkg::phase_code(phase_nxt);
    result.done_res      = done;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2crts_pkg::ST_IDLE;
      reg_id_r   <= '0;
      dev_id_r   <= '0;
      rx_rem_r   <= '0;
      tx_rem_r   <= '0;
      rx_pos_r   <= '0;
      tx_pos_r   <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      reg_id_r   <= reg_id_nxt;
      dev_id_r   <= dev_id_nxt;
      rx_rem_r   <= rx_rem_nxt;
      tx_rem_r   <= tx_rem_nxt;
      rx_pos_r   <= rx_pos_nxt;
      tx_pos_r   <= tx_pos_nxt;
    end
  end

endmodule

FILE: sv/i2c_register_transfer_sequencer_core.sv
// I2C master register transfer sequencer. Each input item is a command (load a
// transmit byte, start a read or write) or a bus event (transmit ready, byte
// received); each gives exactly one result item with the bus requests, the
// phase after the step and any received byte with its index. One item is taken
// per clock unless the input stalls; an item passes an input register, one step
// of sequencer logic and a result register, and its result is offered on the
// output until it is taken. The input register takes an item while a result
// waits if it is empty, so the input stalls only when both stages are full
// behind a stalled output. Transmit bytes sit in a BUFFER_DEPTH-entry RAM
// whose registered read port prefetches the next transmit slot, with a bypass
// for a load to that slot.
module i2c_register_transfer_sequencer_core #(
  parameter int BUFFER_DEPTH = i2crts_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2crts_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2crts_pkg::out_item_t out_item
);

  localparam int AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic                  in_valid_r, in_valid_nxt;
  i2crts_pkg::in_item_t  in_item_r;
  logic                  out_valid_r, out_valid_nxt;
  i2crts_pkg::out_item_t out_item_r;
  i2crts_pkg::out_item_t step_result;
  logic                  in_accept, adv;

  logic                  store_we;
  logic [AddrW-1:0]      store_waddr, store_raddr;
  logic [7:0]            store_wdata, ram_rdata, store_rdata;
  logic                  byp_hit_r;
  logic [7:0]            byp_data_r;

  // Handshake: the input stage moves on when the result register is empty or its result is taken
  assign adv       = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = in_valid_r & out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byp_hit_r   <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      byp_hit_r   <= store_we & (store_waddr == store_raddr);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= step_result;
    end
    byp_data_r <= store_wdata;
  end

  // Transmit store with write-to-read bypass
  i2crts_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH),
    .ADDR_W(AddrW)
  ) u_tx_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .raddr(store_raddr),
    .rdata(ram_rdata)
  );

  assign store_rdata = byp_hit_r ? byp_data_r : ram_rdata;

  // Sequencer step
  i2crts_step #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .ADDR_W      (AddrW)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (in_item_r),
    .store_rdata(store_rdata),
    .result     (step_result),
    .store_we   (store_we),
    .store_waddr(store_waddr),
    .store_wdata(store_wdata),
    .store_raddr(store_raddr)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/i2crts_checker.sv
module i2crts_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input i2crts_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input logic                  out_stall,
  input i2crts_pkg::out_item_t out_item
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Input only backs up when both stages are full behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // An item accepted while no result is offered or stalled reaches the output through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !out_stall |=> ##1 out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind i2c_register_transfer_sequencer_core i2crts_checker u_checker (.*);

FILE: tb/i2c_register_transfer_sequencer_core_checker.sv
module i2c_register_transfer_sequencer_core_checker
  import i2crts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatches,
  output int        awaited,
  output int        checked,
  output int        finished
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = BUFFER_DEPTH_DEF;

  // Shadow copy of the sequencer
  logic [2:0] seq_phase;
  logic [7:0] reg_byte;
  logic [6:0] dev_byte;
  logic [4:0] rx_left;
  logic [4:0] tx_left;
  logic [4:0] rx_pos;
  logic [4:0] tx_pos;
  logic [7:0] tx_bytes [DEPTH];

  out_item_t expected_results [$];
  out_item_t next_result;
  out_item_t oldest_result;

  // One sequencer step: update the shadow state, give the result it causes
  task automatic step_sequencer(input in_item_t it, output out_item_t res);
    logic [4:0] cnt;
    res = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (it.index < DEPTH) tx_bytes[it.index] = it.data;
      end
      CMD_READ, CMD_WRITE: begin
        // a start restarts whatever was going on
        cnt       = (it.count > DEPTH) ? 5'(DEPTH) : it.count;
        seq_phase = PH_REG;
        reg_byte  = it.reg_id;
        dev_byte  = it.dev_id;
        rx_left   = (it.cmd == CMD_READ) ? cnt : 5'd0;
        tx_left   = (it.cmd == CMD_READ) ? 5'd0 : cnt;
        rx_pos    = '0;
        tx_pos    = '0;
        res.start_request = 1'b1;
      end
      CMD_TX_RDY: begin
        if (seq_phase == PH_REG) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = reg_byte;
          seq_phase    = (rx_left != 0) ? PH_SWITCH : PH_TX;
        end else if (seq_phase == PH_SWITCH) begin
          // repeated start in receive direction
          res.start_request = 1'b1;
          seq_phase         = PH_RX;
          if (rx_left == 5'd1) res.stop_request = 1'b1;
        end else if (seq_phase == PH_TX) begin
          if (tx_left != 0) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = (tx_pos < DEPTH) ? tx_bytes[tx_pos[3:0]] : 8'h00;
            tx_pos++;
            tx_left--;
          end else begin
            res.stop_request = 1'b1;
            res.done_res     = 1'b1;
            seq_phase        = PH_IDLE;
          end
        end
      end
      CMD_RX_BYTE: begin
        if (seq_phase == PH_RX) begin
          if (rx_left != 0) begin
            res.rx_valid = 1'b1;
            res.rx_index = rx_pos[3:0];
            res.rx_data  = it.data;
            rx_pos++;
            rx_left--;
          end
          if (rx_left == 5'd1) begin
            res.stop_request = 1'b1;
          end else if (rx_left == 5'd0) begin
            res.done_res = 1'b1;
            seq_phase    = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    res.receive_dir = (seq_phase == PH_RX);
    res.target_addr = dev_byte;
    res.phase       = seq_phase;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_result(input out_item_t want, input out_item_t got);
    check_field("start_request", 8'(want.start_request), 8'(got.start_request));
    check_field("receive_dir",   8'(want.receive_dir),   8'(got.receive_dir));
    check_field("tx_valid",      8'(want.tx_valid),      8'(got.tx_valid));
    check_field("tx_byte",       want.tx_byte,           got.tx_byte);
    check_field("stop_request",  8'(want.stop_request),  8'(got.stop_request));
    check_field("rx_valid",      8'(want.rx_valid),      8'(got.rx_valid));
    check_field("rx_index",      8'(want.rx_index),      8'(got.rx_index));
    check_field("rx_data",       want.rx_data,           got.rx_data);
    check_field("target_addr",   8'(want.target_addr),   8'(got.target_addr));
    check_field("phase",         8'(want.phase),         8'(got.phase));
    check_field("done_res",      8'(want.done_res),      8'(got.done_res));
  endtask

  // Watch both channels; predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase <= PH_IDLE;
      reg_byte  <= '0;
      dev_byte  <= '0;
      rx_left   <= '0;
      tx_left   <= '0;
      rx_pos    <= '0;
      tx_pos    <= '0;
      foreach (tx_bytes[k]) tx_bytes[k] <= '0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        step_sequencer(in_item, next_result);
        expected_results.push_back(next_result);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none, actual %h", $time, out_item);
        end else begin
          oldest_result = expected_results.pop_front();
          compare_result(oldest_result, out_item);
          checked++;
          if (oldest_result.done_res) finished++;
        end
      end
    end
    awaited = expected_results.size();
  end

endmodule

FILE: tb/i2c_register_transfer_sequencer_core_tb.sv
module i2c_register_transfer_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2crts_pkg::*;

  localparam int SLOTS = BUFFER_DEPTH_DEF;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int mismatches;
  int awaited;
  int checked;
  int finished;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int idle_mix  [4] = '{0, 60, 0, 38};
  int stall_mix [4] = '{0, 0, 60, 38};

  // transmit slots written so far; a write never reaches past them
  logic [SLOTS-1:0] slot_loaded = '0;

  i2c_register_transfer_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  i2c_register_transfer_sequencer_core_checker seq_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .awaited    (awaited),
    .checked    (checked),
    .finished   (finished)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("i2c_register_transfer_sequencer_core: mismatch");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Trim a write count so that only loaded slots are sent
  function automatic in_item_t legalise(input in_item_t it);
    int loaded;
    int eff;
    loaded = 0;
    while (loaded < SLOTS && slot_loaded[loaded]) loaded++;
    eff = (it.count > SLOTS) ? SLOTS : it.count;
    if (it.cmd == CMD_WRITE && eff > loaded) it.count = 5'(loaded);
    return it;
  endfunction

  function automatic in_item_t random_fields(input logic [2:0] cmd);
    in_item_t it;
    it.cmd      = cmd;
    it.dev_id   = 7'($urandom_range(127));
    it.reg_id   = 8'($urandom_range(255));
    it.count    = 5'($urandom_range(31));
    it.data     = 8'($urandom_range(255));
    it.index    = 4'($urandom_range(15));
    return it;
  endfunction

  // One input transfer, with optional idle cycles in front
  task automatic send(input in_item_t raw);
    in_item_t it;
    it = legalise(raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    if (it.cmd == CMD_LOAD) slot_loaded[it.index] = 1'b1;
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(input logic [2:0] cmd, input logic [6:0] dev, input logic [7:0] reg_a,
                       input logic [4:0] cnt, input logic [7:0] dat, input logic [3:0] idx);
    in_item_t it;
    it.cmd      = cmd;
    it.dev_id   = dev;
    it.reg_id   = reg_a;
    it.count    = cnt;
    it.data     = dat;
    it.index    = idx;
    send(it);
  endtask

  // A start followed by its bus events, now and then with noise or cut short, or one to four loads
  task automatic random_transfer();
    in_item_t it;
    logic     rd;
    int       eff;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 4)) send(random_fields(CMD_LOAD));
      return;
    end
    rd = 1'($urandom_range(1));
    it = random_fields(rd ? CMD_READ : CMD_WRITE);
    it.count = ($urandom_range(99) < 85) ? 5'($urandom_range(5)) : 5'($urandom_range(31));
    it  = legalise(it);
    eff = (it.count > SLOTS) ? SLOTS : it.count;
    send(it);
    for (int k = 0; k < eff + 2; k++) begin
      if ($urandom_range(99) < 4) break;
      if ($urandom_range(99) < 8) send(random_fields(3'($urandom_range(7))));
      send(random_fields((rd && k >= 2) ? CMD_RX_BYTE : CMD_TX_RDY));
    end
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored events, store extremes, zero counts, clamp, restart
    issue(CMD_RX_BYTE, 7'h00, 8'h00, 5'd0,  8'hFF, 4'h0);
    issue(CMD_TX_RDY,  7'h00, 8'h00, 5'd0,  8'h00, 4'h0);
    issue(3'd7,        7'h7F, 8'hFF, 5'd31, 8'hFF, 4'hF);
    issue(CMD_LOAD,    7'h00, 8'h00, 5'd0,  8'hFF, 4'h0);
    issue(CMD_LOAD,    7'h7F, 8'hFF, 5'd31, 8'h00, 4'h1);
    issue(CMD_LOAD,    7'h00, 8'h00, 5'd0,  8'h5A, 4'hF);
    issue(CMD_WRITE,   7'h7F, 8'hFF, 5'd0,  8'h00, 4'h0);
    repeat (2) issue(CMD_TX_RDY, 7'h00, 8'h00, 5'd0, 8'h00, 4'h0);
    issue(CMD_READ,    7'h00, 8'h00, 5'd0,  8'h00, 4'h0);
    repeat (2) issue(CMD_TX_RDY, 7'h00, 8'h00, 5'd0, 8'h00, 4'h0);
    issue(CMD_READ,    7'h55, 8'hAA, 5'd1,  8'h00, 4'h0);
    repeat (2) issue(CMD_TX_RDY, 7'h00, 8'h00, 5'd0, 8'h00, 4'h0);
    issue(CMD_RX_BYTE, 7'h00, 8'h00, 5'd0,  8'hFF, 4'h0);
    issue(CMD_READ,    7'h2A, 8'h55, 5'd31, 8'h00, 4'h0);
    repeat (2) issue(CMD_TX_RDY, 7'h00, 8'h00, 5'd0, 8'h00, 4'h0);
    issue(CMD_RX_BYTE, 7'h00, 8'h00, 5'd0,  8'h00, 4'h0);
    issue(CMD_TX_RDY,  7'h00, 8'h00, 5'd0,  8'h00, 4'h0);
    issue(CMD_WRITE,   7'h01, 8'h80, 5'd2,  8'h00, 4'h0);
    repeat (4) issue(CMD_TX_RDY, 7'h00, 8'h00, 5'd0, 8'h00, 4'h0);

    // Random transfers under four handshake pressure mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      stall_pct     = stall_mix[ph];
      target        = items_sent + 320;
      while (items_sent < target) random_transfer();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d input items over four idle/stall mixes; %0d results checked,",
             items_sent, checked);
    $display("%0d transfers ran to completion, %0d field mismatches.", finished, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("i2c_register_transfer_sequencer_core: match");
    end else begin
      $display("i2c_register_transfer_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/i2crts_pkg.sv
sv/i2crts_ram.sv
sv/i2crts_step.sv
sv/i2c_register_transfer_sequencer_core.sv
sv/i2crts_checker.sv
tb/i2c_register_transfer_sequencer_core_checker.sv
tb/i2c_register_transfer_sequencer_core_tb.sv
